/* hw/rtl/smc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_pkg
// Types and codes shared by the scalar core step block.
// ----------------------------------------------------------------------------
package smc_pkg;

	localparam logic [1:0] CMD_EXEC  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_START = 2'd3;

	localparam logic [7:0] CFG_SSTEP = 8'd0;
	localparam logic [7:0] CFG_IRQ   = 8'd1;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_REGIMM  = 6'h01;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_BLEZ    = 6'h06;
	localparam logic [5:0] OP_BGTZ    = 6'h07;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0A;
	localparam logic [5:0] OP_SLTIU   = 6'h0B;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_XORI    = 6'h0E;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LH      = 6'h21;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_LBU     = 6'h24;
	localparam logic [5:0] OP_LHU     = 6'h25;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SH      = 6'h29;
	localparam logic [5:0] OP_SW      = 6'h2B;

	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_SRA  = 6'h03;
	localparam logic [5:0] FN_SLLV = 6'h04;
	localparam logic [5:0] FN_SRLV = 6'h06;
	localparam logic [5:0] FN_SRAV = 6'h07;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_JALR = 6'h09;
	localparam logic [5:0] FN_BRK  = 6'h0D;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_XOR  = 6'h26;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLT  = 6'h2A;
	localparam logic [5:0] FN_SLTU = 6'h2B;

	localparam logic [4:0] RI_BLTZ   = 5'h00;
	localparam logic [4:0] RI_BGEZ   = 5'h01;
	localparam logic [4:0] RI_BLTZAL = 5'h10;
	localparam logic [4:0] RI_BGEZAL = 5'h11;

	localparam logic [4:0] LINK_REG = 5'd31;

	localparam logic [1:0] SZ_B = 2'd0;
	localparam logic [1:0] SZ_H = 2'd1;
	localparam logic [1:0] SZ_W = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] instr_word;
		logic [11:0] host_addr;
		logic [31:0] host_wdata;
	} in_item_t;

	typedef struct packed {
		logic [11:0] exec_pc;
		logic [11:0] fetch_pc;
		logic        reg_written;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic [31:0] read_word;
		logic        is_halted;
		logic        is_broke;
		logic        raise_interrupt;
		logic        unknown_op;
	} out_item_t;

	typedef struct packed {
		logic       is_load;
		logic [4:0] rs;
		logic [4:0] rt;
	} cls_t;

	typedef struct packed {
		in_item_t item;
		cls_t     cls;
	} q_item_t;

	typedef struct packed {
		logic step_halt;
		logic irq_on_break;
	} cfg_t;

endpackage

/* hw/rtl/smc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_ram
// Generic single-port-write, registered-read ram.
// ----------------------------------------------------------------------------
module smc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/smc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_front
// Accepts items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module smc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  smc_pkg::in_item_t  in_data,
	input  logic               busy,
	output logic               head_v,
	output smc_pkg::q_item_t   head,
	input  logic               pop
);

	smc_pkg::q_item_t ent_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	smc_pkg::q_item_t nw;
	logic             push;
	logic [5:0]       op;

	always_comb begin
		op = in_data.instr_word[31:26];
		nw.item = in_data;
		nw.cls.rs = in_data.instr_word[25:21];
		nw.cls.rt = in_data.instr_word[20:16];
		case (op) inside
			smc_pkg::OP_LB, smc_pkg::OP_LH, smc_pkg::OP_LW,
			smc_pkg::OP_LBU, smc_pkg::OP_LHU: nw.cls.is_load = 1'b1;
			default: nw.cls.is_load = 1'b0;
		endcase
	end

	assign in_stall = cnt_q[1] || busy;
	assign push = in_valid && !in_stall;
	assign head_v = cnt_q != 2'd0;
	assign head = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= nw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* hw/rtl/smc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_back
// Executes queued items: register file, pc state, byte-banked data memory.
// ----------------------------------------------------------------------------
module smc_back #(
	parameter int DMEM_BYTES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_v,
	input  smc_pkg::q_item_t   head,
	output logic               pop,
	output logic               busy,
	input  smc_pkg::cfg_t      cfg,
	input  logic               out_free,
	output logic               res_v,
	output smc_pkg::out_item_t res
);

	localparam int AW = $clog2(DMEM_BYTES);
	localparam int RW = AW - 2;
	localparam int ROWS = DMEM_BYTES / 4;

	logic          clr_q;
	logic [RW-1:0] clr_cnt_q;

	logic             e1_v_q, e1_new_q;
	smc_pkg::q_item_t e1_q;
	logic [31:0]      s_q, t_q, fv_q;
	logic             fs_q, ft_q;

	logic               e2_v_q, e2_rd_q, e2_sgn_q;
	logic [1:0]         e2_sz_q, e2_lane_q;
	logic [4:0]         e2_rt_q;
	smc_pkg::out_item_t e2_res_q;

	logic [11:0] cur_q, dly_q;
	logic        halt_q, brk_q;

	logic [31:0] rf_s_do, rf_t_do;
	logic [7:0]  bk_do [4];

	logic [31:0] s_op, t_op;

	// execute stage decode
	logic [31:0] w, ze, se, ea, ha32, m_wd, m_sh, rval;
	logic [5:0]  op, fn;
	logic [4:0]  rt_i, rd, sh, ridx;
	logic [11:0] nx_cur, nx_dly, link, btgt, tgt;
	logic        ex, nx_halt, nx_brk, rq, unk, brk, taken;
	logic        m_wr, m_rd, m_sgn, need_e2;
	logic [1:0]  m_sz;
	logic [AW-1:0] m_addr;
	smc_pkg::out_item_t e1_res;

	logic e2_fire, e1_done, ld_haz;
	logic wb_en;
	logic [4:0] wb_idx;
	logic [31:0] wb_val;

	logic [31:0] ld_word, ld_val;
	smc_pkg::out_item_t e2_res;

	assign s_op = e1_new_q ? (fs_q ? fv_q : rf_s_do) : s_q;
	assign t_op = e1_new_q ? (ft_q ? fv_q : rf_t_do) : t_q;

	always_comb begin
		w = e1_q.item.instr_word;
		op = w[31:26];
		fn = w[5:0];
		rt_i = w[20:16];
		rd = w[15:11];
		sh = w[10:6];
		ze = {16'b0, w[15:0]};
		se = {{16{w[15]}}, w[15:0]};
		ea = s_op + se;
		ha32 = {20'b0, e1_q.item.host_addr};
		link = dly_q + 12'd4;
		btgt = dly_q + {w[9:0], 2'b00};
		ex = (e1_q.item.cmd == smc_pkg::CMD_EXEC) && !halt_q;
		nx_cur = cur_q;
		nx_dly = dly_q;
		nx_halt = halt_q;
		nx_brk = brk_q;
		rq = 1'b0;
		ridx = rd;
		rval = 32'b0;
		unk = 1'b0;
		brk = 1'b0;
		taken = 1'b0;
		tgt = btgt;
		m_wr = 1'b0;
		m_rd = 1'b0;
		m_sz = smc_pkg::SZ_W;
		m_sgn = 1'b0;
		m_addr = ea[AW-1:0];
		m_wd = t_op;
		unique case (e1_q.item.cmd)
			smc_pkg::CMD_EXEC: begin
				if (!halt_q) begin
					nx_cur = dly_q;
					nx_dly = link;
					unique case (op) inside
						smc_pkg::OP_SPECIAL: begin
							unique case (fn) inside
								smc_pkg::FN_SLL: begin rq = 1'b1; rval = t_op << sh; end
								smc_pkg::FN_SRL: begin rq = 1'b1; rval = t_op >> sh; end
								smc_pkg::FN_SRA: begin
									rq = 1'b1;
									rval = $unsigned($signed(t_op) >>> sh);
								end
								smc_pkg::FN_SLLV: begin rq = 1'b1; rval = t_op << s_op[4:0]; end
								smc_pkg::FN_SRLV: begin rq = 1'b1; rval = t_op >> s_op[4:0]; end
								smc_pkg::FN_SRAV: begin
									rq = 1'b1;
									rval = $unsigned($signed(t_op) >>> s_op[4:0]);
								end
								smc_pkg::FN_JR: begin taken = 1'b1; tgt = {s_op[11:2], 2'b00}; end
								smc_pkg::FN_JALR: begin
									taken = 1'b1;
									tgt = {s_op[11:2], 2'b00};
									rq = 1'b1;
									rval = {20'b0, link};
								end
								smc_pkg::FN_BRK: brk = 1'b1;
								smc_pkg::FN_ADD, smc_pkg::FN_ADDU: begin
									rq = 1'b1; rval = s_op + t_op;
								end
								smc_pkg::FN_SUB, smc_pkg::FN_SUBU: begin
									rq = 1'b1; rval = s_op - t_op;
								end
								smc_pkg::FN_AND: begin rq = 1'b1; rval = s_op & t_op; end
								smc_pkg::FN_OR: begin rq = 1'b1; rval = s_op | t_op; end
								smc_pkg::FN_XOR: begin rq = 1'b1; rval = s_op ^ t_op; end
								smc_pkg::FN_NOR: begin rq = 1'b1; rval = ~(s_op | t_op); end
								smc_pkg::FN_SLT: begin
									rq = 1'b1;
									rval = {31'b0, $signed(s_op) < $signed(t_op)};
								end
								smc_pkg::FN_SLTU: begin rq = 1'b1; rval = {31'b0, s_op < t_op}; end
								default: unk = 1'b1;
							endcase
						end
						smc_pkg::OP_REGIMM: begin
							ridx = smc_pkg::LINK_REG;
							unique case (rt_i) inside
								smc_pkg::RI_BLTZ: taken = s_op[31];
								smc_pkg::RI_BGEZ: taken = !s_op[31];
								smc_pkg::RI_BLTZAL: begin
									taken = s_op[31]; rq = 1'b1; rval = {20'b0, link};
								end
								smc_pkg::RI_BGEZAL: begin
									taken = !s_op[31]; rq = 1'b1; rval = {20'b0, link};
								end
								default: unk = 1'b1;
							endcase
						end
						smc_pkg::OP_J: begin taken = 1'b1; tgt = {w[9:0], 2'b00}; end
						smc_pkg::OP_JAL: begin
							taken = 1'b1;
							tgt = {w[9:0], 2'b00};
							rq = 1'b1;
							ridx = smc_pkg::LINK_REG;
							rval = {20'b0, link};
						end
						smc_pkg::OP_BEQ: taken = s_op == t_op;
						smc_pkg::OP_BNE: taken = s_op != t_op;
						smc_pkg::OP_BLEZ: taken = s_op[31] || (s_op == 32'b0);
						smc_pkg::OP_BGTZ: taken = !s_op[31] && (s_op != 32'b0);
						smc_pkg::OP_ADDI, smc_pkg::OP_ADDIU: begin
							rq = 1'b1; ridx = rt_i; rval = s_op + se;
						end
						smc_pkg::OP_SLTI: begin
							rq = 1'b1; ridx = rt_i;
							rval = {31'b0, $signed(s_op) < $signed(se)};
						end
						smc_pkg::OP_SLTIU: begin
							rq = 1'b1; ridx = rt_i; rval = {31'b0, s_op < se};
						end
						smc_pkg::OP_ANDI: begin rq = 1'b1; ridx = rt_i; rval = s_op & ze; end
						smc_pkg::OP_ORI: begin rq = 1'b1; ridx = rt_i; rval = s_op | ze; end
						smc_pkg::OP_XORI: begin rq = 1'b1; ridx = rt_i; rval = s_op ^ ze; end
						smc_pkg::OP_LUI: begin rq = 1'b1; ridx = rt_i; rval = {w[15:0], 16'b0}; end
						smc_pkg::OP_LB: begin m_rd = 1'b1; m_sz = smc_pkg::SZ_B; m_sgn = 1'b1; end
						smc_pkg::OP_LH: begin m_rd = 1'b1; m_sz = smc_pkg::SZ_H; m_sgn = 1'b1; end
						smc_pkg::OP_LW: m_rd = 1'b1;
						smc_pkg::OP_LBU: begin m_rd = 1'b1; m_sz = smc_pkg::SZ_B; end
						smc_pkg::OP_LHU: begin m_rd = 1'b1; m_sz = smc_pkg::SZ_H; end
						smc_pkg::OP_SB: begin m_wr = 1'b1; m_sz = smc_pkg::SZ_B; end
						smc_pkg::OP_SH: begin m_wr = 1'b1; m_sz = smc_pkg::SZ_H; end
						smc_pkg::OP_SW: m_wr = 1'b1;
						default: unk = 1'b1;
					endcase
					if (taken) begin
						nx_dly = tgt;
					end
					if (brk) begin
						nx_halt = 1'b1;
						nx_brk = 1'b1;
					end
					if (cfg.step_halt) begin
						nx_halt = 1'b1;
					end
				end
			end
			smc_pkg::CMD_WRITE: begin
				m_wr = 1'b1;
				m_addr = ha32[AW-1:0];
				m_wd = e1_q.item.host_wdata;
			end
			smc_pkg::CMD_READ: begin
				m_rd = 1'b1;
				m_addr = ha32[AW-1:0];
			end
			smc_pkg::CMD_START: begin
				nx_cur = {e1_q.item.host_addr[11:2], 2'b00};
				nx_dly = {e1_q.item.host_addr[11:2], 2'b00} + 12'd4;
				nx_halt = 1'b0;
				nx_brk = 1'b0;
			end
			default: unk = 1'b0;
		endcase
		need_e2 = m_rd;
		case (m_sz)
			smc_pkg::SZ_B: m_sh = {m_wd[7:0], 24'b0};
			smc_pkg::SZ_H: m_sh = {m_wd[15:0], 16'b0};
			default: m_sh = m_wd;
		endcase
		e1_res.exec_pc = ex ? cur_q : 12'd0;
		e1_res.fetch_pc = nx_cur;
		e1_res.reg_written = rq && (ridx != 5'd0);
		e1_res.reg_index = (rq && (ridx != 5'd0)) ? ridx : 5'd0;
		e1_res.reg_value = (rq && (ridx != 5'd0)) ? rval : 32'b0;
		e1_res.read_word = 32'b0;
		e1_res.is_halted = nx_halt;
		e1_res.is_broke = nx_brk;
		e1_res.raise_interrupt = brk && cfg.irq_on_break;
		e1_res.unknown_op = unk;
	end

	// sequencing
	assign e2_fire = e2_v_q && out_free;
	// load whose base register is still being written by the load ahead of it
	assign ld_haz = e1_q.cls.is_load && !e2_rd_q && (e2_rt_q != 5'd0) &&
		(e2_rt_q == e1_q.cls.rs);
	assign e1_done = e1_v_q && (need_e2 ? (!e2_v_q || (e2_fire && !ld_haz)) :
		(!e2_v_q && out_free));
	assign pop = head_v && !clr_q && (!e1_v_q || e1_done);
	assign busy = clr_q;

	// load assembly
	always_comb begin
		ld_word = {bk_do[e2_lane_q], bk_do[e2_lane_q + 2'd1],
			bk_do[e2_lane_q + 2'd2], bk_do[e2_lane_q + 2'd3]};
		case (e2_sz_q)
			smc_pkg::SZ_B: ld_val = {{24{e2_sgn_q && ld_word[31]}}, ld_word[31:24]};
			smc_pkg::SZ_H: ld_val = {{16{e2_sgn_q && ld_word[31]}}, ld_word[31:16]};
			default: ld_val = ld_word;
		endcase
		e2_res = e2_res_q;
		if (e2_rd_q) begin
			e2_res.read_word = ld_word;
		end else if (e2_rt_q != 5'd0) begin
			e2_res.reg_written = 1'b1;
			e2_res.reg_index = e2_rt_q;
			e2_res.reg_value = ld_val;
		end
	end

	always_comb begin
		if (e2_fire && !e2_rd_q && (e2_rt_q != 5'd0)) begin
			wb_en = 1'b1;
			wb_idx = e2_rt_q;
			wb_val = ld_val;
		end else begin
			wb_en = e1_done && e1_res.reg_written;
			wb_idx = ridx;
			wb_val = rval;
		end
		res_v = e2_fire || (e1_done && !need_e2);
		res = e2_v_q ? e2_res : e1_res;
	end

	// register file, duplicated for two read ports
	logic          rf_we;
	logic [4:0]    rf_wa;
	logic [31:0]   rf_wd;
	assign rf_we = clr_q || wb_en;
	assign rf_wa = clr_q ? clr_cnt_q[4:0] : wb_idx;
	assign rf_wd = clr_q ? 32'b0 : wb_val;

	smc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_s (
		.clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
		.re(1'b1), .raddr(head.cls.rs), .rdata(rf_s_do)
	);

	smc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_t (
		.clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
		.re(1'b1), .raddr(head.cls.rt), .rdata(rf_t_do)
	);

	// data memory in four byte lanes
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [1:0]    k;
		logic [AW-1:0] ba;
		logic          en;
		logic [RW-1:0] row;
		logic [7:0]    wd;
		assign k = 2'(b) - m_addr[1:0];
		assign ba = m_addr + AW'(k);
		assign en = (m_sz == smc_pkg::SZ_W) || (k == 2'd0) ||
			((m_sz == smc_pkg::SZ_H) && (k == 2'd1));
		assign row = clr_q ? clr_cnt_q : ba[AW-1:2];
		assign wd = clr_q ? 8'b0 : m_sh[31 - 8 * k -: 8];
		smc_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
			.clk(clk),
			.we(clr_q || (e1_done && m_wr && en)),
			.waddr(row),
			.wdata(wd),
			.re(e1_done && m_rd),
			.raddr(row),
			.rdata(bk_do[b])
		);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			e1_q <= head;
		end
		s_q <= (wb_en && (wb_idx == e1_q.cls.rs)) ? wb_val : s_op;
		t_q <= (wb_en && (wb_idx == e1_q.cls.rt)) ? wb_val : t_op;
		fs_q <= wb_en && (wb_idx == head.cls.rs);
		ft_q <= wb_en && (wb_idx == head.cls.rt);
		fv_q <= wb_val;
		if (e1_done && need_e2) begin
			e2_res_q <= e1_res;
			e2_sz_q <= m_sz;
			e2_sgn_q <= m_sgn;
			e2_lane_q <= m_addr[1:0];
			e2_rd_q <= e1_q.item.cmd == smc_pkg::CMD_READ;
			e2_rt_q <= rt_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			e1_v_q <= 1'b0;
			e1_new_q <= 1'b0;
			e2_v_q <= 1'b0;
			cur_q <= 12'd0;
			dly_q <= 12'd4;
			halt_q <= 1'b1;
			brk_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (&clr_cnt_q) begin
					clr_q <= 1'b0;
				end
			end
			e1_new_q <= pop;
			if (pop) begin
				e1_v_q <= 1'b1;
			end else if (e1_done) begin
				e1_v_q <= 1'b0;
			end
			if (e1_done && need_e2) begin
				e2_v_q <= 1'b1;
			end else if (e2_fire) begin
				e2_v_q <= 1'b0;
			end
			if (e1_done) begin
				cur_q <= nx_cur;
				dly_q <= nx_dly;
				halt_q <= nx_halt;
				brk_q <= nx_brk;
			end
		end
	end

endmodule

/* hw/rtl/scalar_mips_core_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_mips_core_step
// Scalar integer core stepped by host items: execute, memory access, start.
//
// in channel: one command per transfer (execute, write word, read word,
// start). out channel: exactly one result per command, in order.
// cfg channel: always ready; index 0 single step, index 1 irq on break.
// Path: an item goes from the queue through the execute register to the
// output register; one that reads data memory (loads and read-word commands)
// also passes the memory-read register and the registered byte-lane rams.
// Throughput: one item per cycle while the out channel is free; an item
// that follows a memory read waits for that read to leave unless it is
// itself one; a load whose base register the load ahead writes waits too.
// Reset: a clearing pass over all DMEM_BYTES/4 rows zeroes the data memory
// and the register file; in_stall is held high during it. The core comes
// out halted with pc 0.
// A stalled out channel holds its result; the two-entry queue fills and then
// in_stall rises.
// ----------------------------------------------------------------------------
module scalar_mips_core_step #(
	parameter int DMEM_BYTES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  smc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output smc_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	smc_pkg::cfg_t      cfg_q;
	logic               head_v, pop, busy, out_free, res_v;
	smc_pkg::q_item_t   head;
	smc_pkg::out_item_t res;

	assign cfg_ready = 1'b1;
	assign out_free = !out_valid || !out_stall;

	smc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .busy(busy), .head_v(head_v), .head(head), .pop(pop)
	);

	smc_back #(.DMEM_BYTES(DMEM_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n), .head_v(head_v), .head(head), .pop(pop),
		.busy(busy), .cfg(cfg_q), .out_free(out_free), .res_v(res_v), .res(res)
	);

	always_ff @(posedge clk) begin
		if (out_free && res_v) begin
			out_data <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			cfg_q <= '0;
		end else begin
			if (out_free) begin
				out_valid <= res_v;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == smc_pkg::CFG_SSTEP) begin
					cfg_q.step_halt <= cfg_data[0];
				end else if (cfg_index == smc_pkg::CFG_IRQ) begin
					cfg_q.irq_on_break <= cfg_data[0];
				end
			end
		end
	end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the scalar core step block.
//
// Drives host commands and instructions through the in channel, keeps an
// item-level model of the core state to predict each result, and compares
// every result field by field in order. Idle and stall patterns change
// between phases; configuration is rewritten only while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [7:0] CFG_NO_REG = 8'd7;

	class core_scoreboard;
		logic [31:0]        gpr [32];
		logic [7:0]         dmem [4096];
		logic [11:0]        pc, npc;
		logic               halted, broke, sstep, irq_en;
		smc_pkg::out_item_t pending [$];
		int                 errors;

		function void clear();
			foreach (gpr[i]) gpr[i] = '0;
			foreach (dmem[i]) dmem[i] = '0;
			pc = 12'h000; npc = 12'h004; halted = 1'b1; broke = 1'b0;
			sstep = 1'b0; irq_en = 1'b0; errors = 0;
		endfunction

		function void set_cfg(logic [7:0] idx, logic [31:0] val);
			if (idx == smc_pkg::CFG_SSTEP) sstep = val[0];
			else if (idx == smc_pkg::CFG_IRQ) irq_en = val[0];
		endfunction

		function logic [31:0] rd_word(logic [31:0] a);
			rd_word = {dmem[a[11:0]], dmem[12'(a + 1)], dmem[12'(a + 2)],
				dmem[12'(a + 3)]};
		endfunction

		function void wr_bytes(logic [31:0] a, logic [31:0] v, int n);
			for (int k = 0; k < n; k++)
				dmem[12'(a + k)] = v[8 * (n - 1 - k) +: 8];
		endfunction

		function void note_input(smc_pkg::in_item_t it);
			smc_pkg::out_item_t r;
			logic [31:0] w, s, t, se, ze, ea, v;
			logic [4:0] rt, rd, sh;
			logic [11:0] bt;
			logic wr, ok, brk, take;
			logic [4:0] widx;
			r = '0; wr = 0; widx = 0; v = 0; ok = 1; brk = 0;
			case (it.cmd)
				smc_pkg::CMD_EXEC: begin
					if (!halted) begin
						w = it.instr_word;
						r.exec_pc = pc;
						pc = npc & 12'hffc;
						npc = (pc + 12'd4) & 12'hffc;
						s = gpr[w[25:21]]; rt = w[20:16]; t = gpr[rt];
						rd = w[15:11]; sh = w[10:6];
						ze = {16'h0, w[15:0]}; se = {{16{w[15]}}, w[15:0]};
						bt = (pc + 12'(se << 2)) & 12'hffc;
						ea = s + se;
						case (w[31:26])
							smc_pkg::OP_SPECIAL: begin
								widx = rd; wr = 1;
								case (w[5:0])
									smc_pkg::FN_SLL: v = t << sh;
									smc_pkg::FN_SRL: v = t >> sh;
									smc_pkg::FN_SRA: v = $signed(t) >>> sh;
									smc_pkg::FN_SLLV: v = t << s[4:0];
									smc_pkg::FN_SRLV: v = t >> s[4:0];
									smc_pkg::FN_SRAV: v = $signed(t) >>> s[4:0];
									smc_pkg::FN_JR: begin wr = 0; npc = s[11:0] & 12'hffc; end
									smc_pkg::FN_JALR: begin
										npc = s[11:0] & 12'hffc;
										v = {20'h0, (pc + 12'd4) & 12'hffc};
									end
									smc_pkg::FN_BRK: begin wr = 0; brk = 1; end
									smc_pkg::FN_ADD, smc_pkg::FN_ADDU: v = s + t;
									smc_pkg::FN_SUB, smc_pkg::FN_SUBU: v = s - t;
									smc_pkg::FN_AND: v = s & t;
									smc_pkg::FN_OR: v = s | t;
									smc_pkg::FN_XOR: v = s ^ t;
									smc_pkg::FN_NOR: v = ~(s | t);
									smc_pkg::FN_SLT: v = {31'h0, $signed(s) < $signed(t)};
									smc_pkg::FN_SLTU: v = {31'h0, s < t};
									default: begin wr = 0; ok = 0; end
								endcase
							end
							smc_pkg::OP_REGIMM: begin
								take = 0;
								case (rt)
									smc_pkg::RI_BLTZ: take = s[31];
									smc_pkg::RI_BGEZ: take = !s[31];
									smc_pkg::RI_BLTZAL, smc_pkg::RI_BGEZAL: begin
										take = (rt == smc_pkg::RI_BLTZAL) ? s[31] : !s[31];
										wr = 1; widx = smc_pkg::LINK_REG;
										v = {20'h0, (pc + 12'd4) & 12'hffc};
									end
									default: ok = 0;
								endcase
								if (ok && take) npc = bt;
							end
							smc_pkg::OP_J: npc = {w[9:0], 2'b00};
							smc_pkg::OP_JAL: begin
								wr = 1; widx = smc_pkg::LINK_REG;
								v = {20'h0, (pc + 12'd4) & 12'hffc};
								npc = {w[9:0], 2'b00};
							end
							smc_pkg::OP_BEQ: if (s == t) npc = bt;
							smc_pkg::OP_BNE: if (s != t) npc = bt;
							smc_pkg::OP_BLEZ: if (s[31] || s == 0) npc = bt;
							smc_pkg::OP_BGTZ: if (!s[31] && s != 0) npc = bt;
							smc_pkg::OP_ADDI, smc_pkg::OP_ADDIU: begin
								wr = 1; widx = rt; v = s + se;
							end
							smc_pkg::OP_SLTI: begin
								wr = 1; widx = rt; v = {31'h0, $signed(s) < $signed(se)};
							end
							smc_pkg::OP_SLTIU: begin wr = 1; widx = rt; v = {31'h0, s < se}; end
							smc_pkg::OP_ANDI: begin wr = 1; widx = rt; v = s & ze; end
							smc_pkg::OP_ORI: begin wr = 1; widx = rt; v = s | ze; end
							smc_pkg::OP_XORI: begin wr = 1; widx = rt; v = s ^ ze; end
							smc_pkg::OP_LUI: begin wr = 1; widx = rt; v = ze << 16; end
							smc_pkg::OP_LB: begin
								wr = 1; widx = rt;
								v = {{24{dmem[ea[11:0]][7]}}, dmem[ea[11:0]]};
							end
							smc_pkg::OP_LBU: begin wr = 1; widx = rt; v = {24'h0, dmem[ea[11:0]]}; end
							smc_pkg::OP_LH: begin
								wr = 1; widx = rt; v = rd_word(ea) >> 16;
								v = {{16{v[15]}}, v[15:0]};
							end
							smc_pkg::OP_LHU: begin wr = 1; widx = rt; v = rd_word(ea) >> 16; end
							smc_pkg::OP_LW: begin wr = 1; widx = rt; v = rd_word(ea); end
							smc_pkg::OP_SB: wr_bytes(ea, t, 1);
							smc_pkg::OP_SH: wr_bytes(ea, t, 2);
							smc_pkg::OP_SW: wr_bytes(ea, t, 4);
							default: ok = 0;
						endcase
						if (wr && widx != 0) begin
							gpr[widx] = v; r.reg_written = 1; r.reg_index = widx;
							r.reg_value = v;
						end
						r.unknown_op = !ok;
						if (brk) begin halted = 1; broke = 1; r.raise_interrupt = irq_en; end
						if (sstep) halted = 1;
					end
				end
				smc_pkg::CMD_WRITE: wr_bytes({20'h0, it.host_addr}, it.host_wdata, 4);
				smc_pkg::CMD_READ: r.read_word = rd_word({20'h0, it.host_addr});
				default: begin
					pc = it.host_addr & 12'hffc; npc = (pc + 12'd4) & 12'hffc;
					halted = 0; broke = 0;
				end
			endcase
			r.fetch_pc = pc; r.is_halted = halted; r.is_broke = broke;
			pending.push_back(r);
		endfunction

		function void cmp(string name, logic [31:0] e, logic [31:0] g);
			if (g !== e) begin
				$error("%s exp %h got %h", name, e, g);
				errors++;
			end
		endfunction

		function void check_result(smc_pkg::out_item_t got);
			smc_pkg::out_item_t e;
			if (pending.size() == 0) begin
				$error("result with no expectation: %h", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			cmp("exec_pc", 32'(e.exec_pc), 32'(got.exec_pc));
			cmp("fetch_pc", 32'(e.fetch_pc), 32'(got.fetch_pc));
			cmp("reg_written", 32'(e.reg_written), 32'(got.reg_written));
			cmp("reg_index", 32'(e.reg_index), 32'(got.reg_index));
			cmp("reg_value", e.reg_value, got.reg_value);
			cmp("read_word", e.read_word, got.read_word);
			cmp("is_halted", 32'(e.is_halted), 32'(got.is_halted));
			cmp("is_broke", 32'(e.is_broke), 32'(got.is_broke));
			cmp("raise_interrupt", 32'(e.raise_interrupt), 32'(got.raise_interrupt));
			cmp("unknown_op", 32'(e.unknown_op), 32'(got.unknown_op));
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
	smc_pkg::in_item_t in_data;
	smc_pkg::out_item_t out_data;
	logic [7:0] cfg_index;
	logic [31:0] cfg_data;
	core_scoreboard sb;
	int send_idle, recv_idle, cycles;
	localparam int CYCLE_LIMIT = 400000;

	scalar_mips_core_step uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle);

	// valid stays high into the next call so items can follow back to back
	task automatic send_item(smc_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(it);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_cfg(logic [7:0] idx, logic [31:0] val);
		drain();
		cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_cfg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic smc_pkg::in_item_t mk(logic [1:0] c, logic [31:0] w,
		logic [11:0] a, logic [31:0] d);
		smc_pkg::in_item_t it;
		it.cmd = c; it.instr_word = w; it.host_addr = a; it.host_wdata = d;
		return it;
	endfunction

	function automatic smc_pkg::in_item_t exe(logic [31:0] w);
		return mk(smc_pkg::CMD_EXEC, w, 12'h0, 32'h0);
	endfunction

	function automatic smc_pkg::in_item_t rnd_item(logic [1:0] c, logic [31:0] w);
		return mk(c, w, 12'($urandom()), $urandom());
	endfunction

	function automatic logic [31:0] rand_instr();
		logic [5:0] ops [24] = '{smc_pkg::OP_SPECIAL, smc_pkg::OP_SPECIAL,
			smc_pkg::OP_SPECIAL, smc_pkg::OP_REGIMM, smc_pkg::OP_J, smc_pkg::OP_JAL,
			smc_pkg::OP_BEQ, smc_pkg::OP_BNE, smc_pkg::OP_BLEZ, smc_pkg::OP_BGTZ,
			smc_pkg::OP_ADDI, smc_pkg::OP_ADDIU, smc_pkg::OP_SLTI, smc_pkg::OP_SLTIU,
			smc_pkg::OP_ANDI, smc_pkg::OP_ORI, smc_pkg::OP_XORI, smc_pkg::OP_LUI,
			smc_pkg::OP_LB, smc_pkg::OP_LH, smc_pkg::OP_LW, smc_pkg::OP_LBU,
			smc_pkg::OP_LHU, smc_pkg::OP_SW};
		logic [5:0] fns [19] = '{smc_pkg::FN_SLL, smc_pkg::FN_SRL, smc_pkg::FN_SRA,
			smc_pkg::FN_SLLV, smc_pkg::FN_SRLV, smc_pkg::FN_SRAV, smc_pkg::FN_JR,
			smc_pkg::FN_JALR, smc_pkg::FN_BRK, smc_pkg::FN_ADD, smc_pkg::FN_ADDU,
			smc_pkg::FN_SUB, smc_pkg::FN_SUBU, smc_pkg::FN_AND, smc_pkg::FN_OR,
			smc_pkg::FN_XOR, smc_pkg::FN_NOR, smc_pkg::FN_SLT, smc_pkg::FN_SLTU};
		logic [4:0] ris [4] = '{smc_pkg::RI_BLTZ, smc_pkg::RI_BGEZ,
			smc_pkg::RI_BLTZAL, smc_pkg::RI_BGEZAL};
		logic [31:0] w;
		int p;
		w = $urandom();
		p = $urandom_range(99);
		if (p < 8) return w;
		if (p < 12) w[31:26] = ($urandom_range(1)) ? smc_pkg::OP_SB : smc_pkg::OP_SH;
		else w[31:26] = ops[$urandom_range(23)];
		if (w[31:26] == smc_pkg::OP_SPECIAL && $urandom_range(9) != 0) begin
			w[5:0] = fns[$urandom_range(18)];
			if (w[5:0] == smc_pkg::FN_BRK && $urandom_range(3) != 0) w[5:0] = smc_pkg::FN_ADDU;
		end
		if (w[31:26] == smc_pkg::OP_REGIMM && $urandom_range(7) != 0)
			w[20:16] = ris[$urandom_range(3)];
		return w;
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) begin
			int p;
			p = $urandom_range(99);
			if (sb.halted && p < 60) send_item(rnd_item(smc_pkg::CMD_START, $urandom()));
			else if (p < 80) send_item(rnd_item(smc_pkg::CMD_EXEC, rand_instr()));
			else if (p < 88) send_item(rnd_item(smc_pkg::CMD_WRITE, $urandom()));
			else if (p < 95) send_item(rnd_item(smc_pkg::CMD_READ, $urandom()));
			else send_item(rnd_item(smc_pkg::CMD_START, $urandom()));
			if (i == n / 2 && n > 100) drain();
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		cycles = 0;
		arst_n = 0; in_valid = 0; in_data = '0; out_stall = 0;
		cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		send_idle = 0; recv_idle = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed part
		send_item(exe(32'h2001_0001));
		send_item(mk(smc_pkg::CMD_WRITE, 32'h0, 12'hffe, 32'h8081_ff7f));
		send_item(mk(smc_pkg::CMD_READ, 32'h0, 12'hffe, 32'h0));
		send_item(mk(smc_pkg::CMD_START, 32'h0, 12'hfff, 32'h0));
		send_item(exe({smc_pkg::OP_LUI, 5'd0, 5'd1, 16'hffff}));
		send_item(exe({smc_pkg::OP_ORI, 5'd1, 5'd1, 16'hffff}));
		send_item(exe({smc_pkg::OP_ADDIU, 5'd1, 5'd0, 16'h0005}));
		send_item(exe({smc_pkg::OP_LB, 5'd0, 5'd2, 16'hffff}));
		send_item(exe({smc_pkg::OP_LW, 5'd0, 5'd3, 16'hfffe}));
		send_item(exe({smc_pkg::OP_SW, 5'd1, 5'd3, 16'h0002}));
		send_item(exe({smc_pkg::OP_SPECIAL, 5'd1, 5'd1, 5'd4, 5'd31, smc_pkg::FN_SRA}));
		send_item(exe({smc_pkg::OP_SPECIAL, 5'd3, 5'd1, 5'd5, 5'd0, smc_pkg::FN_SLT}));
		send_item(exe({smc_pkg::OP_BEQ, 5'd0, 5'd0, 16'h8000}));
		send_item(exe({smc_pkg::OP_JAL, 26'h3ff_ffff}));
		send_item(exe({smc_pkg::OP_REGIMM, 5'd1, smc_pkg::RI_BLTZAL, 16'h7fff}));
		send_item(exe({smc_pkg::OP_SPECIAL, 5'd1, 5'd0, 5'd7, 5'd0, smc_pkg::FN_JALR}));
		send_item(exe(32'hffff_ffff));
		send_item(exe({smc_pkg::OP_SPECIAL, 20'h0, smc_pkg::FN_BRK}));
		send_item(exe(32'h2001_0001));
		write_cfg(smc_pkg::CFG_IRQ, 32'h1);
		write_cfg(smc_pkg::CFG_SSTEP, 32'h1);
		send_item(mk(smc_pkg::CMD_START, 32'h0, 12'h010, 32'h0));
		send_item(exe({smc_pkg::OP_ADDIU, 5'd0, 5'd9, 16'h1234}));
		send_item(mk(smc_pkg::CMD_START, 32'h0, 12'h020, 32'h0));
		send_item(exe({smc_pkg::OP_SPECIAL, 20'h0, smc_pkg::FN_BRK}));
		write_cfg(CFG_NO_REG, 32'hffff_ffff);

		send_idle = 15; recv_idle = 86;
		run_random(150);
		write_cfg(smc_pkg::CFG_SSTEP, 32'h0);
		run_random(350);
		send_idle = 86; recv_idle = 15;
		write_cfg(smc_pkg::CFG_IRQ, 32'h0);
		run_random(300);
		write_cfg(smc_pkg::CFG_SSTEP, 32'h1);
		run_random(100);
		send_idle = 0; recv_idle = 0;
		write_cfg(smc_pkg::CFG_SSTEP, 32'h0);
		write_cfg(smc_pkg::CFG_IRQ, 32'h1);
		run_random(550);

		drain();
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
